FILE: design/bsr_pkg.sv
// ----------------------------------------------------------------------------
// Bracket sequence ranker package
// Widths, symbol codes and default sizing that both the ranker and its
// completion-count table use.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // Width of the pair count register and of one input symbol.
    localparam int PAIR_W = 5;
    localparam int SYM_W  = 2;

    // Width of a completion count and of the rank.
    localparam int CNT_W = 53;

    // Default largest number of bracket pairs.
    localparam int MAX_PAIRS_DEF = 20;

    // Bracket symbols in lexicographic order.
    typedef enum logic [SYM_W-1:0] {
        SYM_OPEN_ROUND   = 2'd0,
        SYM_CLOSE_ROUND  = 2'd1,
        SYM_OPEN_SQUARE  = 2'd2,
        SYM_CLOSE_SQUARE = 2'd3
    } sym_t;

    // Stack entry codes for the bracket type.
    localparam logic TYPE_ROUND  = 1'b0;
    localparam logic TYPE_SQUARE = 1'b1;

endpackage

FILE: design/bsr_count_rom.sv
// ----------------------------------------------------------------------------
// Completion count table
// Constant table of the number of ways to close a given depth in a given
// number of symbols, with two registered read ports.
// ----------------------------------------------------------------------------
module bsr_count_rom
    import bsr_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF,
    parameter int ROW_W     = $clog2(MAX_PAIRS + 2),
    parameter int COL_W     = $clog2(2 * MAX_PAIRS + 1)
)
(
    input  logic             clk,
    input  logic             rd_en,
    input  logic [ROW_W-1:0] row_a,
    input  logic [ROW_W-1:0] row_b,
    input  logic [COL_W-1:0] col,
    output logic [CNT_W-1:0] data_a,
    output logic [CNT_W-1:0] data_b
);

    localparam int ROWS   = MAX_PAIRS + 2;
    localparam int COLS   = 2 * MAX_PAIRS + 1;
    localparam int ENTRY  = ROWS * COLS;
    localparam int ADDR_W = $clog2(ENTRY);

    // Table build: one close step leads from depth i to i-1, and each open
    // step offers two bracket types, so it counts twice.
    function automatic logic [ENTRY*CNT_W-1:0] build_counts();
        logic [ENTRY*CNT_W-1:0] t;
        logic [CNT_W-1:0]       v;
        int                     i;
        int                     j;
        t = '0;
        t[0 +: CNT_W] = CNT_W'(1);
        for (j = 1; j < COLS; j++) begin
            for (i = 0; i < ROWS; i++) begin
                v = '0;
                if (i > 0) begin
                    v = v + t[((i - 1) * COLS + (j - 1)) * CNT_W +: CNT_W];
                end
                if (i + 1 < ROWS) begin
                    v = v + (t[((i + 1) * COLS + (j - 1)) * CNT_W +: CNT_W] << 1);
                end
                t[(i * COLS + j) * CNT_W +: CNT_W] = v;
            end
        end
        return t;
    endfunction

    localparam logic [ENTRY*CNT_W-1:0] CC_FLAT = build_counts();

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;

    // Row-major addressing.
    assign addr_a = ADDR_W'(row_a) * ADDR_W'(COLS) + ADDR_W'(col);
    assign addr_b = ADDR_W'(row_b) * ADDR_W'(COLS) + ADDR_W'(col);

    // Registered read data on both ports.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_a <= CC_FLAT[addr_a * CNT_W +: CNT_W];
            data_b <= CC_FLAT[addr_b * CNT_W +: CNT_W];
        end
    end

endmodule

FILE: design/bracket_sequence_ranker.sv
// ----------------------------------------------------------------------------
// Bracket sequence ranker
// Ranks a balanced two-type bracket sequence, one symbol per transaction,
// and delivers the rank with a malformed flag after the last symbol.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   ---------------------  ---------------------------
//  config    cfg_write              cfg_data (pair count)
//  input     in_valid / in_stall    symbol
//  output    out_valid / out_stall  rank, malformed
//
// One symbol is taken every cycle while the input does not stall. A symbol
// updates the bracket stack when it is taken and reads two table entries
// into the registered read ports; its rank share is then added from that
// data, and the sum for the last symbol is written to the output register.
// Reset clears the sequence state and sets the pair count to one. The input
// stalls only while a finished result waits in the output register and
// another finished result stands behind it.
// ----------------------------------------------------------------------------
module bracket_sequence_ranker
    import bsr_pkg::*;
#(
    parameter int MAX_PAIRS = MAX_PAIRS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [PAIR_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [SYM_W-1:0]  symbol,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [CNT_W-1:0]  rank,
    output logic              malformed
);

    localparam int DW    = $clog2(MAX_PAIRS + 1);
    localparam int ROW_W = $clog2(MAX_PAIRS + 2);
    localparam int SW    = $clog2(2 * MAX_PAIRS + 1);
    localparam int SIW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;

    // Sequence state.
    logic [PAIR_W-1:0] pair_count_reg;
    logic [DW-1:0]     depth_reg,  depth_next;
    logic [SW-1:0]     seen_reg,   seen_next;
    logic              error_reg,  error_next;
    logic              stack_reg [MAX_PAIRS];

    // Second stage.
    logic              s1_valid_reg;
    sym_t              s1_sym_reg;
    logic              s1_b_en_reg;
    logic              s1_last_reg;
    logic              s1_bad_reg;
    logic [CNT_W-1:0]  rank_sum_reg, rank_sum_next;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  rank_reg;
    logic              malformed_reg;

    // Stage one signals.
    logic              hold;
    logic              accept;
    sym_t              sym;
    logic [PAIR_W-1:0] pairs_eff;
    logic [SW-1:0]     len;
    logic [SW-1:0]     seen_eff;
    logic [SW-1:0]     rem;
    logic              last;
    logic [DW-1:0]     depth_m1;
    logic              top_type;
    logic              is_open;
    logic              sym_type;
    logic              push_ok;
    logic              b_en;
    logic [ROW_W-1:0]  row_a;
    logic [ROW_W-1:0]  row_b;
    logic [CNT_W-1:0]  cnt_a;
    logic [CNT_W-1:0]  cnt_b;
    logic [CNT_W-1:0]  add;
    logic [CNT_W-1:0]  sum;

    // Handshake: only a finished result blocked behind a full output stalls.
    assign hold     = s1_valid_reg && s1_last_reg && out_valid_reg && out_stall;
    assign in_stall = hold;
    assign accept   = in_valid && !hold;

    assign sym = sym_t'(symbol);

    // Effective pair count and remaining length.
    always_comb
    begin
        if (pair_count_reg == '0)
        begin
            pairs_eff = PAIR_W'(1);
        end
        else if (pair_count_reg > PAIR_W'(MAX_PAIRS))
        begin
            pairs_eff = PAIR_W'(MAX_PAIRS);
        end
        else
        begin
            pairs_eff = pair_count_reg;
        end
    end

    assign len      = SW'(pairs_eff) << 1;
    assign seen_eff = (seen_reg >= len) ? (len - SW'(1)) : seen_reg;
    assign rem      = len - seen_eff - SW'(1);
    assign last     = (seen_eff == len - SW'(1));

    // Stack top and symbol decode.
    assign depth_m1 = depth_reg - DW'(1);
    assign top_type = (depth_reg != '0) ? stack_reg[depth_m1[SIW-1:0]] : TYPE_ROUND;
    assign is_open  = (sym == SYM_OPEN_ROUND) || (sym == SYM_OPEN_SQUARE);
    assign sym_type = (sym == SYM_OPEN_SQUARE) || (sym == SYM_CLOSE_SQUARE);
    assign push_ok  = is_open && (depth_reg < DW'(MAX_PAIRS));
    assign b_en     = (depth_reg != '0) && (top_type == TYPE_ROUND);

    // Table rows: one deeper, and one shallower for the square open.
    assign row_a = ROW_W'(depth_reg) + ROW_W'(1);
    assign row_b = (depth_reg != '0) ? ROW_W'(depth_m1) : '0;

    // Stack, depth and error update for the accepted symbol.
    always_comb
    begin
        depth_next = depth_reg;
        error_next = error_reg;
        seen_next  = seen_eff + SW'(1);
        if (is_open)
        begin
            if (push_ok)
            begin
                depth_next = depth_reg + DW'(1);
            end
            else
            begin
                error_next = 1'b1;
            end
        end
        else if (depth_reg == '0)
        begin
            error_next = 1'b1;
        end
        else
        begin
            if (top_type != sym_type)
            begin
                error_next = 1'b1;
            end
            depth_next = depth_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg <= PAIR_W'(1);
            depth_reg      <= '0;
            seen_reg       <= '0;
            error_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            pair_count_reg <= cfg_data;
            depth_reg      <= '0;
            seen_reg       <= '0;
            error_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                depth_reg <= '0;
                seen_reg  <= '0;
                error_reg <= 1'b0;
            end
            else
            begin
                depth_reg <= depth_next;
                seen_reg  <= seen_next;
                error_reg <= error_next;
            end
        end
    end

    // Bracket type stack; entries are read only below the current depth.
    always_ff @(posedge clk)
    begin
        if (accept && push_ok && !cfg_write)
        begin
            stack_reg[depth_reg[SIW-1:0]] <= sym_type;
        end
    end

    // Completion count table.
    bsr_count_rom #(
        .MAX_PAIRS (MAX_PAIRS),
        .ROW_W     (ROW_W),
        .COL_W     (SW)
    ) u_count_rom (
        .clk    (clk),
        .rd_en  (accept),
        .row_a  (row_a),
        .row_b  (row_b),
        .col    (rem),
        .data_a (cnt_a),
        .data_b (cnt_b)
    );

    // Stage one to stage two register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s1_valid_reg <= accept && !cfg_write;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sym_reg  <= sym;
            s1_b_en_reg <= b_en;
            s1_last_reg <= last;
            s1_bad_reg  <= error_next || (depth_next != '0);
        end
    end

    // Rank share of the symbol: counts for every smaller allowed symbol.
    always_comb
    begin
        case (s1_sym_reg)
            SYM_OPEN_ROUND:   add = '0;
            SYM_CLOSE_ROUND:  add = cnt_a;
            SYM_OPEN_SQUARE:  add = cnt_a + (s1_b_en_reg ? cnt_b : '0);
            SYM_CLOSE_SQUARE: add = cnt_a << 1;
            default:          add = '0;
        endcase
    end

    assign sum = rank_sum_reg + add;

    always_comb
    begin
        rank_sum_next = rank_sum_reg;
        if (s1_valid_reg && !hold)
        begin
            rank_sum_next = s1_last_reg ? '0 : sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_sum_reg <= '0;
        end
        else if (cfg_write)
        begin
            rank_sum_reg <= '0;
        end
        else
        begin
            rank_sum_reg <= rank_sum_next;
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_valid_reg && s1_last_reg && !hold)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_last_reg && !hold)
        begin
            rank_reg      <= sum;
            malformed_reg <= s1_bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign rank      = rank_reg;
    assign malformed = malformed_reg;

endmodule
